@@ rtl/core/rti_pkg.sv @@
// Shared constants and codes for the ray-triangle intersection block.
`timescale 1ns / 1ps
`default_nettype none

package rti_pkg;

    // Default geometry format: signed Q8.8 coordinates
    localparam int COORD_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 8;

    // Result distance, Q16.8 unsigned
    localparam int DIST_W = 24;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Configuration register file
    localparam int DET_EPS_W  = 48;
    localparam int T_EPS_W    = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] REG_DET_EPS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_T_EPS   = 2'd1;

    // Input word function codes
    localparam logic FUNC_VERTEX = 1'b0;
    localparam logic FUNC_RAY    = 1'b1;

    // Number of stored vertices; vertex index 3 is ignored
    localparam int NUM_VERTS = 3;

    // Queue between the geometry front and the divide back
    localparam int QUEUE_DEPTH = 4;

endpackage

`default_nettype wire

@@ rtl/core/rti_front.sv @@
// Geometry front: vertex store, edge vectors, cross and dot products, culling tests.
`timescale 1ns / 1ps
`default_nettype none

module rti_front
    import rti_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int PW          = 3 * COORD_WIDTH + 6
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [DET_EPS_W-1:0]          det_eps,
    input  wire logic                          s_valid,
    output      logic                          s_ready,
    input  wire logic                          s_func,
    input  wire logic [1:0]                    s_vertex_index,
    input  wire logic signed [COORD_WIDTH-1:0] s_pos_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_pos_y,
    input  wire logic signed [COORD_WIDTH-1:0] s_pos_z,
    input  wire logic signed [COORD_WIDTH-1:0] s_dir_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_dir_y,
    input  wire logic signed [COORD_WIDTH-1:0] s_dir_z,
    input  wire logic                          q_full,
    output      logic                          q_push,
    output      logic [2*PW:0]                 q_data
);

    localparam int CW   = COORD_WIDTH;
    localparam int EW   = CW + 1;
    localparam int HW   = 2 * CW + 2;
    localparam int QW   = 2 * CW + 3;
    localparam int CMPW = (PW > DET_EPS_W) ? PW : DET_EPS_W;

    // Vertex store
    logic signed [CW-1:0] vtx_reg [NUM_VERTS][3];

    // Stage registers
    logic             v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic signed [EW-1:0] e1_reg [3], e2_reg [3], sv_reg [3];
    logic signed [CW-1:0] dir_reg [3];
    logic signed [EW-1:0] e1b_reg [3], e2b_reg [3], svb_reg [3];
    logic signed [CW-1:0] dirb_reg [3];
    logic signed [HW-1:0] hp_reg [6];
    logic signed [QW-1:0] qp_reg [6];
    logic signed [EW-1:0] e1c_reg [3], e2c_reg [3], svc_reg [3];
    logic signed [CW-1:0] dirc_reg [3];
    logic signed [HW-1:0] h_reg [3];
    logic signed [QW-1:0] qv_reg [3];
    logic signed [PW-1:0] detp_reg [3], unp_reg [3], vnp_reg [3], tnp_reg [3];
    logic signed [PW-1:0] det_reg, un_reg, vn_reg, tn_reg;

    logic                 adv;
    logic                 accept;
    logic signed [CW-1:0] pos [3];
    logic signed [CW-1:0] dir [3];
    logic signed [PW:0]   uv_sum;
    logic                 det_ok, un_ok, vn_ok, tn_ok;

    assign pos[0] = s_pos_x;
    assign pos[1] = s_pos_y;
    assign pos[2] = s_pos_z;
    assign dir[0] = s_dir_x;
    assign dir[1] = s_dir_y;
    assign dir[2] = s_dir_z;

    // Whole front moves together; it holds only when the last word can't enter the queue
    assign adv     = !v5_reg || !q_full;
    assign s_ready = adv;
    assign accept  = s_valid && adv;

    // Vertex store writes; index 3 is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_VERTS; i++) begin
                for (int j = 0; j < 3; j++) begin
                    vtx_reg[i][j] <= '0;
                end
            end
        end else if (accept && s_func == FUNC_VERTEX && s_vertex_index != 2'd3) begin
            for (int j = 0; j < 3; j++) begin
                vtx_reg[s_vertex_index][j] <= pos[j];
            end
        end
    end

    // Valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid && s_func == FUNC_RAY;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Datapath stages
    always_ff @(posedge aclk) begin
        if (adv) begin
            // Edges and origin offset
            for (int j = 0; j < 3; j++) begin
                e1_reg[j]  <= EW'(vtx_reg[1][j]) - EW'(vtx_reg[0][j]);
                e2_reg[j]  <= EW'(vtx_reg[2][j]) - EW'(vtx_reg[0][j]);
                sv_reg[j]  <= EW'(pos[j]) - EW'(vtx_reg[0][j]);
                dir_reg[j] <= dir[j];
            end
            // Cross product terms: h = dir x e2, q = s x e1
            for (int i = 0; i < 3; i++) begin
                hp_reg[2*i]   <= HW'(dir_reg[(i+1)%3]) * HW'(e2_reg[(i+2)%3]);
                hp_reg[2*i+1] <= HW'(dir_reg[(i+2)%3]) * HW'(e2_reg[(i+1)%3]);
                qp_reg[2*i]   <= QW'(sv_reg[(i+1)%3]) * QW'(e1_reg[(i+2)%3]);
                qp_reg[2*i+1] <= QW'(sv_reg[(i+2)%3]) * QW'(e1_reg[(i+1)%3]);
            end
            for (int j = 0; j < 3; j++) begin
                e1b_reg[j]  <= e1_reg[j];
                e2b_reg[j]  <= e2_reg[j];
                svb_reg[j]  <= sv_reg[j];
                dirb_reg[j] <= dir_reg[j];
            end
            // Cross differences
            for (int i = 0; i < 3; i++) begin
                h_reg[i]    <= hp_reg[2*i] - hp_reg[2*i+1];
                qv_reg[i]   <= qp_reg[2*i] - qp_reg[2*i+1];
                e1c_reg[i]  <= e1b_reg[i];
                e2c_reg[i]  <= e2b_reg[i];
                svc_reg[i]  <= svb_reg[i];
                dirc_reg[i] <= dirb_reg[i];
            end
            // Dot product terms
            for (int i = 0; i < 3; i++) begin
                detp_reg[i] <= PW'(e1c_reg[i]) * PW'(h_reg[i]);
                unp_reg[i]  <= PW'(svc_reg[i]) * PW'(h_reg[i]);
                vnp_reg[i]  <= PW'(dirc_reg[i]) * PW'(qv_reg[i]);
                tnp_reg[i]  <= PW'(e2c_reg[i]) * PW'(qv_reg[i]);
            end
            // Dot product sums
            det_reg <= detp_reg[0] + detp_reg[1] + detp_reg[2];
            un_reg  <= unp_reg[0] + unp_reg[1] + unp_reg[2];
            vn_reg  <= vnp_reg[0] + vnp_reg[1] + vnp_reg[2];
            tn_reg  <= tnp_reg[0] + tnp_reg[1] + tnp_reg[2];
        end
    end

    // Culling and barycentric bounds, checked against det without dividing
    always_comb begin
        uv_sum = (PW+1)'(un_reg) + (PW+1)'(vn_reg);
        det_ok = (det_reg > 0) &&
                 (CMPW'($unsigned(det_reg)) >= CMPW'(det_eps));
        un_ok  = (un_reg >= 0) && (un_reg <= det_reg);
        vn_ok  = (vn_reg >= 0) && (uv_sum <= (PW+1)'(det_reg));
        tn_ok  = (tn_reg > 0);
    end

    assign q_push = v5_reg && !q_full;
    assign q_data = {det_ok && un_ok && vn_ok && tn_ok, tn_reg, det_reg};

endmodule

`default_nettype wire

@@ rtl/core/rti_queue.sv @@
// Short word queue between the geometry front and the divide back.
`timescale 1ns / 1ps
`default_nettype none

module rti_queue
    import rti_pkg::*;
#(
    parameter int DATA_W = 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output      logic              full,
    input  wire logic              pop,
    output      logic              empty,
    output      logic [DATA_W-1:0] pop_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/rti_back.sv @@
// Divide back: pipelined restoring division for t, saturation and distance test.
`timescale 1ns / 1ps
`default_nettype none

module rti_back
    import rti_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int PW        = 3 * COORD_WIDTH_DEF + 6
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [T_EPS_W-1:0]  t_eps,
    input  wire logic                q_empty,
    input  wire logic [2*PW:0]       q_data,
    output      logic                q_pop,
    output      logic                m_valid,
    input  wire logic                m_ready,
    output      logic                m_hit,
    output      logic [DIST_W-1:0]   m_distance
);

    localparam int RW = PW + DIST_W;

    logic              v_reg    [DIST_W+1];
    logic              pass_reg [DIST_W+1];
    logic              sat_reg  [DIST_W+1];
    logic [RW-1:0]     r_reg    [DIST_W+1];
    logic [PW-1:0]     d_reg    [DIST_W+1];
    logic [DIST_W-1:0] quo_reg  [DIST_W+1];

    logic              m_valid_reg;
    logic              m_hit_reg;
    logic [DIST_W-1:0] m_distance_reg;

    logic              adv;
    logic              in_pass;
    logic [PW-1:0]     in_tn, in_det;
    logic [RW-1:0]     in_num;
    logic [RW-1:0]     r_next   [DIST_W];
    logic [DIST_W-1:0] quo_next [DIST_W];
    logic              t_hit;

    // Back pipeline moves together; holds only when the result word is not taken
    assign adv   = !m_valid_reg || m_ready;
    assign q_pop = adv && !q_empty;

    assign {in_pass, in_tn, in_det} = q_data;
    assign in_num = RW'(in_tn) << FRAC_BITS;

    // One quotient bit per stage, most significant first
    for (genvar k = 0; k < DIST_W; k++) begin : g_div
        localparam int B = DIST_W - 1 - k;
        logic [RW-1:0] dsh;
        assign dsh = RW'(d_reg[k]) << B;
        always_comb begin
            quo_next[k] = quo_reg[k];
            if (r_reg[k] >= dsh) begin
                r_next[k]      = r_reg[k] - dsh;
                quo_next[k][B] = 1'b1;
            end else begin
                r_next[k] = r_reg[k];
            end
        end
    end

    // Valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= DIST_W; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            v_reg[0] <= !q_empty;
            for (int k = 0; k < DIST_W; k++) begin
                v_reg[k+1] <= v_reg[k];
            end
        end
    end

    // Divider stages; quotients beyond 24 bits are caught at entry
    always_ff @(posedge aclk) begin
        if (adv) begin
            pass_reg[0] <= in_pass;
            sat_reg[0]  <= (in_num >= (RW'(in_det) << DIST_W));
            r_reg[0]    <= in_num;
            d_reg[0]    <= in_det;
            quo_reg[0]  <= '0;
            for (int k = 0; k < DIST_W; k++) begin
                pass_reg[k+1] <= pass_reg[k];
                sat_reg[k+1]  <= sat_reg[k];
                r_reg[k+1]    <= r_next[k];
                d_reg[k+1]    <= d_reg[k];
                quo_reg[k+1]  <= quo_next[k];
            end
        end
    end

    assign t_hit = quo_reg[DIST_W] > t_eps;

    // Output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= v_reg[DIST_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (!pass_reg[DIST_W]) begin
                m_hit_reg      <= 1'b0;
                m_distance_reg <= '0;
            end else if (sat_reg[DIST_W]) begin
                m_hit_reg      <= 1'b1;
                m_distance_reg <= DIST_MAX;
            end else begin
                m_hit_reg      <= t_hit;
                m_distance_reg <= t_hit ? quo_reg[DIST_W] : '0;
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_hit      = m_hit_reg;
    assign m_distance = m_distance_reg;

endmodule

`default_nettype wire

@@ rtl/core/ray_triangle_intersect_top.sv @@
// Top level of the ray-triangle intersection block: config registers, front, queue, back.
// Throughput: one word per cycle while s_ready is high (a held result can fill the queue);
// vertex writes take effect for the next word.
// The front is a 5-stage product pipeline, the back a 24-stage divider, one bit per stage.
// Reset (aresetn low, synchronous): vertex store cleared, det_epsilon and t_epsilon set to 1,
// queue and all valid bits cleared.
`timescale 1ns / 1ps
`default_nettype none

module ray_triangle_intersect_top
    import rti_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         cfg_wdata,
    input  wire logic                          s_valid,
    output      logic                          s_ready,
    input  wire logic                          s_func,
    input  wire logic [1:0]                    s_vertex_index,
    input  wire logic signed [COORD_WIDTH-1:0] s_pos_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_pos_y,
    input  wire logic signed [COORD_WIDTH-1:0] s_pos_z,
    input  wire logic signed [COORD_WIDTH-1:0] s_dir_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_dir_y,
    input  wire logic signed [COORD_WIDTH-1:0] s_dir_z,
    output      logic                          m_valid,
    input  wire logic                          m_ready,
    output      logic                          m_hit,
    output      logic [DIST_W-1:0]             m_distance
);

    localparam int PW = 3 * COORD_WIDTH + 6;
    localparam int QDW = 2 * PW + 1;

    logic [DET_EPS_W-1:0] det_eps_reg;
    logic [T_EPS_W-1:0]   t_eps_reg;

    logic           q_push, q_full, q_pop, q_empty;
    logic [QDW-1:0] q_in, q_out;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            det_eps_reg <= DET_EPS_W'(1);
            t_eps_reg   <= T_EPS_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DET_EPS: det_eps_reg <= cfg_wdata[DET_EPS_W-1:0];
                REG_T_EPS:   t_eps_reg   <= cfg_wdata[T_EPS_W-1:0];
                default: ;
            endcase
        end
    end

    rti_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .PW          (PW)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .det_eps        (det_eps_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_vertex_index (s_vertex_index),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_pos_z        (s_pos_z),
        .s_dir_x        (s_dir_x),
        .s_dir_y        (s_dir_y),
        .s_dir_z        (s_dir_z),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_data         (q_in)
    );

    rti_queue #(
        .DATA_W (QDW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_out)
    );

    rti_back #(
        .FRAC_BITS (FRAC_BITS),
        .PW        (PW)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .t_eps      (t_eps_reg),
        .q_empty    (q_empty),
        .q_data     (q_out),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_hit      (m_hit),
        .m_distance (m_distance)
    );

endmodule

`default_nettype wire

@@ verif/ray_triangle_intersect_top_tb.sv @@
// Self-checking testbench for the ray-triangle intersection top level.
`timescale 1ns / 1ps

module ray_triangle_intersect_top_tb;
    import rti_pkg::*;

    localparam int CW = COORD_WIDTH_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int PIPE_LAT = 31;
    localparam int N_RAND = 230;
    localparam int N_PHASES = 5;
    localparam int HOLD_LEN = 200;

    typedef logic [2:0][CW-1:0] vec3_t;

    // One stimulus word, with an optional typed-in expectation
    typedef struct {
        logic              func;
        logic [1:0]        vidx;
        vec3_t             pos;
        vec3_t             dir;
        bit                typed;
        logic              hit;
        logic [DIST_W-1:0] distance;
    } word_t;

    typedef struct {
        logic              hit;
        logic [DIST_W-1:0] distance;
    } hit_rec_t;

    logic aclk;
    logic aresetn;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic s_valid;
    logic s_ready;
    logic s_func;
    logic [1:0] s_vertex_index;
    logic signed [CW-1:0] s_pos_x, s_pos_y, s_pos_z;
    logic signed [CW-1:0] s_dir_x, s_dir_y, s_dir_z;
    logic m_valid;
    logic m_ready;
    logic m_hit;
    logic [DIST_W-1:0] m_distance;

    ray_triangle_intersect_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func),
        .s_vertex_index(s_vertex_index),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y), .s_pos_z(s_pos_z),
        .s_dir_x(s_dir_x), .s_dir_y(s_dir_y), .s_dir_z(s_dir_z),
        .m_valid(m_valid), .m_ready(m_ready), .m_hit(m_hit), .m_distance(m_distance)
    );

    // Mirror of the triangle store and thresholds
    logic signed [CW-1:0] tri_vtx [3][3];
    logic [DET_EPS_W-1:0] det_min;
    logic [T_EPS_W-1:0]   t_min;

    hit_rec_t pending_hits [$];
    int  n_errors = 0;
    int  n_rays = 0;
    int  n_hits = 0;
    int  n_vtx = 0;
    int  n_checked = 0;
    bit  quiet = 0;

    // Clock
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Watchdog
    initial begin
        #3000000;
        $display("Timeout at %0t", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Moller-Trumbore with culling, exact integer math
    function automatic hit_rec_t trace_ray(vec3_t p, vec3_t d);
        longint v0[3], e1[3], e2[3], s[3], dv[3], h[3], q[3];
        longint det, un, vn, tn, t;
        hit_rec_t r;
        r.hit = 1'b0;
        r.distance = '0;
        for (int i = 0; i < 3; i++) begin
            v0[i] = longint'(tri_vtx[0][i]);
            e1[i] = longint'(tri_vtx[1][i]) - v0[i];
            e2[i] = longint'(tri_vtx[2][i]) - v0[i];
            s[i]  = longint'($signed(p[i])) - v0[i];
            dv[i] = longint'($signed(d[i]));
        end
        h[0] = dv[1] * e2[2] - dv[2] * e2[1];
        h[1] = dv[2] * e2[0] - dv[0] * e2[2];
        h[2] = dv[0] * e2[1] - dv[1] * e2[0];
        det = e1[0] * h[0] + e1[1] * h[1] + e1[2] * h[2];
        if (det <= 0 || det < longint'({16'd0, det_min})) return r;
        un = s[0] * h[0] + s[1] * h[1] + s[2] * h[2];
        if (un < 0 || un > det) return r;
        q[0] = s[1] * e1[2] - s[2] * e1[1];
        q[1] = s[2] * e1[0] - s[0] * e1[2];
        q[2] = s[0] * e1[1] - s[1] * e1[0];
        vn = dv[0] * q[0] + dv[1] * q[1] + dv[2] * q[2];
        if (vn < 0 || un + vn > det) return r;
        tn = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
        if (tn <= 0) return r;
        t = (tn <<< FB) / det;
        if (t <= longint'(t_min)) return r;
        r.hit = 1'b1;
        r.distance = (t > longint'(DIST_MAX)) ? DIST_MAX : t[DIST_W-1:0];
        return r;
    endfunction

    function automatic vec3_t v3(int x, int y, int z);
        vec3_t v;
        v[0] = x[CW-1:0];
        v[1] = y[CW-1:0];
        v[2] = z[CW-1:0];
        return v;
    endfunction

    function automatic word_t mk_word(logic f, logic [1:0] vi, vec3_t p, vec3_t d,
                                      bit typed = 0, logic h = 0, int distance = 0);
        word_t w;
        w.func = f;
        w.vidx = vi;
        w.pos = p;
        w.dir = d;
        w.typed = typed;
        w.hit = h;
        w.distance = distance[DIST_W-1:0];
        return w;
    endfunction

    function automatic int rnd_s(int lim);
        return $urandom_range(0, 2 * lim) - lim;
    endfunction

    // Random word: mostly rays aimed into or near the stored triangle
    function automatic word_t rand_word();
        word_t w;
        int sel, a, b, k;
        longint tgt[3], org[3];
        sel = $urandom_range(0, 99);
        w = mk_word(FUNC_RAY, 2'($urandom), vec3_t'({$urandom, $urandom}),
                    vec3_t'({$urandom, $urandom}));
        if (sel < 12) begin
            // vertex write, sometimes full range, sometimes to the ignored slot
            w.func = FUNC_VERTEX;
            if ($urandom_range(0, 9) == 0) w.vidx = 2'd3;
            else w.vidx = 2'($urandom_range(0, 2));
            if ($urandom_range(0, 4) != 0)
                w.pos = v3(rnd_s(4096), rnd_s(4096), rnd_s(4096));
        end else if (sel < 85) begin
            // aimed ray: target on the plane at barycentric (a, b) / 256
            a = $urandom_range(0, 300);
            b = $urandom_range(0, 300 - (a > 280 ? 280 : a));
            k = $urandom_range(1, 4);
            for (int i = 0; i < 3; i++) begin
                tgt[i] = longint'(tri_vtx[0][i])
                       + ((longint'(tri_vtx[1][i]) - longint'(tri_vtx[0][i])) * a
                       +  (longint'(tri_vtx[2][i]) - longint'(tri_vtx[0][i])) * b) / 256;
                org[i] = longint'(rnd_s(4096));
                w.pos[i] = org[i][CW-1:0];
                w.dir[i] = 16'(((tgt[i] - org[i]) / k));
            end
        end
        return w;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_DET_EPS) det_min = val[DET_EPS_W-1:0];
        else if (idx == REG_T_EPS) t_min = val[T_EPS_W-1:0];
    endtask

    // Offer one word and wait for it to be taken; update the mirror on accept
    task automatic send_word(word_t w, bit gap_ok);
        hit_rec_t r;
        s_valid <= 1'b1;
        s_func <= w.func;
        s_vertex_index <= w.vidx;
        s_pos_x <= w.pos[0];
        s_pos_y <= w.pos[1];
        s_pos_z <= w.pos[2];
        s_dir_x <= w.dir[0];
        s_dir_y <= w.dir[1];
        s_dir_z <= w.dir[2];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (w.func == FUNC_VERTEX) begin
            n_vtx++;
            if (w.vidx < 2'd3)
                for (int i = 0; i < 3; i++) tri_vtx[w.vidx][i] = w.pos[i];
        end else begin
            n_rays++;
            if (w.typed) begin
                r.hit = w.hit;
                r.distance = w.distance;
            end else begin
                r = trace_ray(w.pos, w.dir);
            end
            if (r.hit) n_hits++;
            pending_hits.push_back(r);
        end
        if (gap_ok && !quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        while (pending_hits.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT + 10) @(posedge aclk);
    endtask

    // Result checker and receiver backpressure
    initial begin
        int burst;
        int hold;
        bit held;
        hit_rec_t e;
        burst = 0;
        hold = 0;
        held = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                n_checked++;
                if (pending_hits.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result hit=%0b distance=%0d",
                             $time, m_hit, m_distance);
                end else begin
                    e = pending_hits.pop_front();
                    if (m_hit !== e.hit) begin
                        n_errors++;
                        $display("%0t: hit expected %0b actual %0b", $time, e.hit, m_hit);
                    end
                    if (m_distance !== e.distance) begin
                        n_errors++;
                        $display("%0t: distance expected %0d actual %0d",
                                 $time, e.distance, m_distance);
                    end
                end
            end
            // one long hold partway through so the pipeline backs up
            if (!held && n_checked >= 60) begin
                held = 1;
                hold = HOLD_LEN;
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 3) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Main sequence
    initial begin
        word_t dir_tab [$];
        logic [DET_EPS_W-1:0] det_cfg [N_PHASES];
        logic [T_EPS_W-1:0]   t_cfg   [N_PHASES];
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_func = FUNC_VERTEX;
        s_vertex_index = '0;
        s_pos_x = '0; s_pos_y = '0; s_pos_z = '0;
        s_dir_x = '0; s_dir_y = '0; s_dir_z = '0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) tri_vtx[i][j] = '0;
        det_min = 1;
        t_min = 1;

        det_cfg[0] = 1;                  t_cfg[0] = 1;
        det_cfg[1] = 0;                  t_cfg[1] = 0;
        det_cfg[2] = {DET_EPS_W{1'b1}};  t_cfg[2] = {T_EPS_W{1'b1}};
        det_cfg[3] = 48'h1_0000;         t_cfg[3] = 24'd128;
        det_cfg[4] = 48'h100_0000;       t_cfg[4] = 24'd2048;

        // Directed words: empty store, ignored slot, unit triangle, extremes
        dir_tab.push_back(mk_word(FUNC_RAY, 0, v3(0, 0, 0), v3(256, 256, 256), 1, 0, 0));
        dir_tab.push_back(mk_word(FUNC_VERTEX, 3, v3(32767, 32767, 32767), v3(-1, -1, -1)));
        dir_tab.push_back(mk_word(FUNC_RAY, 3, v3(64, 64, 256), v3(0, 0, -256), 1, 0, 0));
        dir_tab.push_back(mk_word(FUNC_VERTEX, 0, v3(0, 0, 0), v3(0, 0, 0)));
        dir_tab.push_back(mk_word(FUNC_VERTEX, 1, v3(256, 0, 0), v3(0, 0, 0)));
        dir_tab.push_back(mk_word(FUNC_VERTEX, 2, v3(0, 256, 0), v3(0, 0, 0)));
        dir_tab.push_back(mk_word(FUNC_RAY, 0, v3(64, 64, 256), v3(0, 0, -256), 1, 1, 256));
        dir_tab.push_back(mk_word(FUNC_RAY, 0, v3(0, 0, 256), v3(0, 0, -256), 1, 1, 256));
        // back face, parallel, behind origin, zero direction
        dir_tab.push_back(mk_word(FUNC_RAY, 0, v3(64, 64, -256), v3(0, 0, 256), 1, 0, 0));
        dir_tab.push_back(mk_word(FUNC_RAY, 0, v3(64, 64, 256), v3(256, 0, 0), 1, 0, 0));
        dir_tab.push_back(mk_word(FUNC_RAY, 0, v3(64, 64, -256), v3(0, 0, -256), 1, 0, 0));
        dir_tab.push_back(mk_word(FUNC_RAY, 0, v3(64, 64, 256), v3(0, 0, 0), 1, 0, 0));
        dir_tab.push_back(mk_word(FUNC_RAY, 0, v3(512, 512, 256), v3(0, 0, -256)));
        dir_tab.push_back(mk_word(FUNC_RAY, 0, v3(128, 128, 256), v3(0, 0, -256)));
        dir_tab.push_back(mk_word(FUNC_RAY, 0, v3(64, 64, 32767), v3(0, 0, -1)));
        dir_tab.push_back(mk_word(FUNC_RAY, 0, v3(-32768, -32768, 32767),
                                  v3(32767, 32767, -32768)));
        dir_tab.push_back(mk_word(FUNC_RAY, 0, v3(32767, 32767, 32767),
                                  v3(-32768, -32768, -32768)));
        dir_tab.push_back(mk_word(FUNC_VERTEX, 0, v3(-32768, -32768, -32768), v3(-1, -1, -1)));
        dir_tab.push_back(mk_word(FUNC_VERTEX, 1, v3(32767, -32768, -32768), v3(-1, -1, -1)));
        dir_tab.push_back(mk_word(FUNC_VERTEX, 2, v3(-32768, 32767, 32767), v3(-1, -1, -1)));
        dir_tab.push_back(mk_word(FUNC_RAY, 0, v3(-32768, 32767, -32768),
                                  v3(16384, -16384, 16384)));
        dir_tab.push_back(mk_word(FUNC_RAY, 0, v3(0, 0, 0), v3(1, 1, -1)));
        dir_tab.push_back(mk_word(FUNC_RAY, 0, v3(0, -32768, 0), v3(0, 256, -256)));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        foreach (dir_tab[i]) send_word(dir_tab[i], 1);
        s_valid <= 1'b0;

        // Random phases, each under its own thresholds
        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            write_reg(REG_DET_EPS, CFG_DATA_W'(det_cfg[ph]));
            write_reg(REG_T_EPS, CFG_DATA_W'(t_cfg[ph]));
            if (ph == 0) begin
                // restart from a modest triangle so aimed rays fit the ports
                send_word(mk_word(FUNC_VERTEX, 0, v3(0, 0, 0), v3(0, 0, 0)), 0);
                send_word(mk_word(FUNC_VERTEX, 1, v3(2048, 0, 0), v3(0, 0, 0)), 0);
                send_word(mk_word(FUNC_VERTEX, 2, v3(0, 2048, 512), v3(0, 0, 0)), 0);
            end
            for (int n = 0; n < N_RAND; n++) begin
                if (ph == N_PHASES - 1 && n >= N_RAND - 150) quiet = 1;
                send_word(rand_word(), 1);
            end
            s_valid <= 1'b0;
        end

        drain();
        $display("Covered %0d rays (%0d hits) and %0d vertex writes over %0d threshold settings",
                 n_rays, n_hits, n_vtx, N_PHASES);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/rti_pkg.sv
rtl/core/rti_front.sv
rtl/core/rti_queue.sv
rtl/core/rti_back.sv
rtl/core/ray_triangle_intersect_top.sv
verif/ray_triangle_intersect_top_tb.sv
